### hw/rtl/fcds_pkg.sv
`default_nettype none
package fcds_pkg;

  localparam int NumChannels = 4;
  localparam int ChBits      = 2;
  localparam int CountBits   = 16;
  localparam int CtrlBits    = 10;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_HBLANK = 2'd1,
    OP_VBLANK = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_SRC  = 2'd0,
    REG_DST  = 2'd1,
    REG_LEN  = 2'd2,
    REG_CTRL = 2'd3
  } reg_e;

  localparam logic [1:0] TimeImmediate = 2'd0;
  localparam logic [1:0] TimeVblank    = 2'd1;
  localparam logic [1:0] TimeHblank    = 2'd2;

  localparam logic [1:0] ModeDec    = 2'd1;
  localparam logic [1:0] ModeFixed  = 2'd2;
  localparam logic [1:0] ModeReload = 2'd3;

  // One channel's working state, held in the working memory.
  typedef struct packed {
    logic [31:0]          src;
    logic [31:0]          dst;
    logic [CountBits-1:0] cnt;
  } work_t;

  // One channel's programmed state, held in the programmed memory.
  typedef struct packed {
    logic [31:0]          src;
    logic [31:0]          dst;
    logic [CountBits-1:0] cnt;
  } prog_t;

  // Result item.
  typedef struct packed {
    logic              irq;
    logic              done;
    logic              word;
    logic [31:0]       waddr;
    logic [31:0]       raddr;
    logic [ChBits-1:0] ch;
    logic              valid;
  } result_t;

  function automatic logic [31:0] step_addr(logic [31:0] a, logic [1:0] mode,
                                            logic word);
    logic [31:0] sz;
    sz = word ? 32'd4 : 32'd2;
    case (mode)
      ModeDec:   step_addr = a - sz;
      ModeFixed: step_addr = a;
      default:   step_addr = a + sz;
    endcase
  endfunction

endpackage
`default_nettype wire

### hw/rtl/fcds_ram.sv
`default_nettype none
module fcds_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/four_channel_dma_sequencer_unit.sv
// Flow: an item is accepted while its channel's entries are read from the memories; the
//   next cycle does the read-modify-write and pushes the result into the output queue,
//   which offers it to the output.
// Throughput: one item per cycle while results are taken; a two-entry output queue holds
//   results in a stall; input stops when it lacks room for the stage-1 item and one more.
// Reset: asynchronous and active low; control bits, busy, the active channel and the
//   programmed-entry flags clear at once. The programmed memory needs no clearing pass
//   because an entry whose flag is still clear reads as zero, and the working memory is
//   always loaded by a rising enable before a tick can read it.
`default_nettype none
module four_channel_dma_sequencer_unit
  import fcds_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, lowest bit up: operation[1:0], channel[3:2], register_select[5:4],
  // write_value[37:6], zero fill [39:38].
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, lowest bit up: xfer_valid[0], xfer_channel[2:1], read_address[34:3],
  // write_address[66:35], word_unit[67], block_done[68], irq_request[69],
  // zero fill [71:70].
  output logic      [71:0] m_axis_tdata
);

  // Control words, busy and the active channel live in flip-flops; they decide
  // every item and must be current without read latency. Addresses and counts
  // live in two small synchronous memories.
  logic [CtrlBits-1:0] ctrl_q [NumChannels];
  logic                busy_q;
  logic [ChBits-1:0]   act_q;

  // One flag per channel that is set once any programmed register of that
  // channel has been written; until then the programmed entry reads as zero.
  logic [NumChannels-1:0] pg_vld_q;

  // Stage 1: item registered while the memories are read.
  logic              s1_valid_q;
  logic [1:0]        s1_op_q;
  logic [ChBits-1:0] s1_ch_q;
  logic [1:0]        s1_sel_q;
  logic [31:0]       s1_val_q;

  // Output queue, two entries; the input stops when they lack room for stage 1 and a new item.
  result_t           oq_q [2];
  logic [1:0]        oq_cnt_q;
  logic              oq_rd_q;

  logic accept, pop;
  assign pop    = m_axis_tvalid && m_axis_tready;
  // One item can be in stage 1, so allow input only with room for it and the new one.
  assign s_axis_tready = (oq_cnt_q == 2'd0) || ((oq_cnt_q == 2'd1) && !s1_valid_q) ||
                         ((oq_cnt_q == 2'd1) && pop) ||
                         ((oq_cnt_q == 2'd2) && !s1_valid_q && pop);
  assign accept = s_axis_tvalid && s_axis_tready;

  logic [1:0]        in_op;
  logic [ChBits-1:0] in_ch;
  assign in_op = s_axis_tdata[1:0];
  assign in_ch = s_axis_tdata[3:2];

  // The memories are read for the channel that the item will touch: the
  // addressed channel for writes, the active channel for ticks. The item in
  // stage 1 may change the active channel in the same cycle, so a following
  // tick reads the channel that will be active after it.
  logic [ChBits-1:0] rd_ch_eff;
  logic [ChBits-1:0] act_d;
  logic              busy_d;
  assign rd_ch_eff = (in_op == OP_WRITE) ? in_ch : act_d;

  work_t wk_rd, wk_wr;
  prog_t pg_rd, pg_wr;
  logic  wk_we, pg_we;
  logic [ChBits-1:0] wr_ch;

  fcds_ram #(.Width($bits(work_t)), .Depth(NumChannels)) u_work (
    .clk_i, .we_i(wk_we), .waddr_i(wr_ch), .wdata_i(wk_wr),
    .raddr_i(rd_ch_eff), .rdata_o(wk_rd)
  );
  fcds_ram #(.Width($bits(prog_t)), .Depth(NumChannels)) u_prog (
    .clk_i, .we_i(pg_we), .waddr_i(wr_ch), .wdata_i(pg_wr),
    .raddr_i(rd_ch_eff), .rdata_o(pg_rd)
  );

  // Forwarding: stage 1 writes in the same cycle the next item reads, so a
  // registered copy of the last write overrides a same-entry read.
  logic        fw_wk_q, fw_pg_q;
  logic [ChBits-1:0] fw_ch_q, s1_rd_ch_q;
  work_t       fw_wk_data_q;
  prog_t       fw_pg_data_q;
  work_t       wk;
  prog_t       pg;
  assign wk = (fw_wk_q && fw_ch_q == s1_rd_ch_q) ? fw_wk_data_q : wk_rd;
  assign pg = (fw_pg_q && fw_ch_q == s1_rd_ch_q) ? fw_pg_data_q :
              (pg_vld_q[s1_rd_ch_q] ? pg_rd : '0);

  // Stage 1 processing.
  logic [CtrlBits-1:0] c, ctrl_new;
  logic                ctrl_we;
  result_t             res;
  logic [CountBits-1:0] cnt_dec;
  logic                 hit;
  logic [ChBits-1:0]    hit_ch;
  logic [1:0]           ev_time;

  always_comb begin
    busy_d   = busy_q;
    act_d    = act_q;
    wk_we    = 1'b0;
    pg_we    = 1'b0;
    wk_wr    = wk;
    pg_wr    = pg;
    wr_ch    = s1_ch_q;
    ctrl_we  = 1'b0;
    ctrl_new = ctrl_q[s1_ch_q];
    res      = '0;
    c        = ctrl_q[act_q];
    cnt_dec  = wk.cnt - 1'b1;
    hit      = 1'b0;
    hit_ch   = '0;
    ev_time  = (s1_op_q == OP_HBLANK) ? TimeHblank : TimeVblank;
    for (int i = NumChannels - 1; i >= 0; i--) begin
      if (ctrl_q[i][0] && ctrl_q[i][2:1] == ev_time) begin
        hit    = 1'b1;
        hit_ch = ChBits'(i);
      end
    end
    if (s1_valid_q) begin
      unique case (op_e'(s1_op_q))
        OP_WRITE: begin
          unique case (reg_e'(s1_sel_q))
            REG_SRC: begin pg_we = 1'b1; pg_wr.src = s1_val_q; end
            REG_DST: begin pg_we = 1'b1; pg_wr.dst = s1_val_q; end
            REG_LEN: begin pg_we = 1'b1; pg_wr.cnt = s1_val_q[CountBits-1:0]; end
            REG_CTRL: begin
              ctrl_we  = 1'b1;
              ctrl_new = s1_val_q[CtrlBits-1:0];
              if (s1_val_q[0] && !ctrl_q[s1_ch_q][0]) begin
                wk_we = 1'b1;
                wk_wr = '{src: pg.src, dst: pg.dst, cnt: pg.cnt};
                if (s1_val_q[2:1] == TimeImmediate) begin
                  busy_d = 1'b1;
                  act_d  = s1_ch_q;
                end
              end else if (!s1_val_q[0] && busy_q && act_q == s1_ch_q) begin
                busy_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
        OP_HBLANK, OP_VBLANK: begin
          if (hit) begin
            busy_d = 1'b1;
            act_d  = hit_ch;
          end
        end
        OP_TICK: begin
          wr_ch = act_q;
          if (busy_q) begin
            if (!c[0]) begin
              busy_d = 1'b0;
            end else begin
              res.valid = 1'b1;
              res.ch    = act_q;
              res.raddr = wk.src;
              res.waddr = wk.dst;
              res.word  = c[7];
              wk_we     = 1'b1;
              wk_wr.dst = step_addr(wk.dst, c[4:3], c[7]);
              wk_wr.src = step_addr(wk.src, c[6:5], c[7]);
              wk_wr.cnt = cnt_dec;
              if (cnt_dec == '0) begin
                res.done = 1'b1;
                res.irq  = c[9];
                if (c[8]) begin
                  wk_wr.cnt = pg.cnt;
                  if (c[4:3] == ModeReload) wk_wr.dst = pg.dst;
                  if (c[2:1] != TimeImmediate) busy_d = 1'b0;
                end else begin
                  wr_ch    = act_q;
                  ctrl_we  = 1'b1;
                  ctrl_new = c & ~CtrlBits'(1);
                  busy_d   = 1'b0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic push;
  assign push = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) ctrl_q[i] <= '0;
      busy_q     <= 1'b0;
      act_q      <= '0;
      pg_vld_q   <= '0;
      s1_valid_q <= 1'b0;
      oq_cnt_q   <= '0;
      oq_rd_q    <= 1'b0;
      fw_wk_q    <= 1'b0;
      fw_pg_q    <= 1'b0;
    end else begin
      busy_q <= busy_d;
      act_q  <= act_d;
      if (ctrl_we) ctrl_q[wr_ch] <= ctrl_new;
      if (pg_we) pg_vld_q[wr_ch] <= 1'b1;
      s1_valid_q <= accept;
      fw_wk_q    <= wk_we;
      fw_pg_q    <= pg_we;
      // The tail entry sits one past the head when the queue holds an item.
      if (push) oq_q[oq_rd_q ^ oq_cnt_q[0]] <= res;
      if (pop) oq_rd_q <= !oq_rd_q;
      oq_cnt_q <= oq_cnt_q + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= s_axis_tdata[1:0];
      s1_ch_q    <= s_axis_tdata[3:2];
      s1_sel_q   <= s_axis_tdata[5:4];
      s1_val_q   <= s_axis_tdata[37:6];
      s1_rd_ch_q <= rd_ch_eff;
    end
    fw_ch_q      <= wr_ch;
    fw_wk_data_q <= wk_wr;
    fw_pg_data_q <= pg_wr;
  end

  result_t head;
  assign head          = oq_q[oq_rd_q];
  assign m_axis_tvalid = (oq_cnt_q != 2'd0);
  assign m_axis_tdata  = {2'b00, head.irq, head.done, head.word, head.waddr,
                          head.raddr, head.ch, head.valid};

  // The queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) oq_cnt_q <= 2'd2)
    else $error("output queue overflow");
  // A result is never pushed into a full queue unless one leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && oq_cnt_q == 2'd2) |-> pop)
    else $error("push into full queue");
  // A done result is always a moving unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.done) |-> res.valid)
    else $error("done without transfer");

endmodule
`default_nettype wire
